/* sv/nvme_controller_register_file_defines.svh */
// ----------------------------------------------------------------------------
// nvme controller register file assertion macros
// concurrent check helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef NVME_CONTROLLER_REGISTER_FILE_DEFINES_SVH
`define NVME_CONTROLLER_REGISTER_FILE_DEFINES_SVH

// same-cycle implication
`define NVMRF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nvmrf same-cycle check failed");

// next-cycle implication
`define NVMRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nvmrf next-cycle check failed");

`endif

/* sv/nvmrf_pkg.sv */
// ----------------------------------------------------------------------------
// nvmrf_pkg
// shared constants, types and helpers of the nvme controller register file
// ----------------------------------------------------------------------------
package nvmrf_pkg;

   // register space geometry
   localparam int unsigned SPACE_BYTES = 8192;
   localparam int unsigned STORE_WORDS = (SPACE_BYTES + 3) / 4;
   localparam int unsigned IDX_W       = $clog2(STORE_WORDS);
   localparam logic [16:0] SPACE_LIMIT = 17'(SPACE_BYTES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_WORDS - 1);

   // reset contents and magic
   localparam logic [63:0] CAP_VALUE  = 64'h0028_0000_0001_0FFF;
   localparam logic [31:0] VS_VALUE   = 32'h0001_0400;
   localparam logic [31:0] NSSR_MAGIC = 32'h4E56_4D65;
   localparam logic [31:0] ONES_32    = 32'hFFFF_FFFF;
   localparam logic [63:0] ONES_64    = 64'hFFFF_FFFF_FFFF_FFFF;

   // byte offsets of the special words
   localparam logic [15:0] OFF_CAP_LO = 16'h0000;
   localparam logic [15:0] OFF_CAP_HI = 16'h0004;
   localparam logic [15:0] OFF_VS     = 16'h0008;
   localparam logic [15:0] OFF_INTMS  = 16'h000C;
   localparam logic [15:0] OFF_INTMC  = 16'h0010;
   localparam logic [15:0] OFF_CC     = 16'h0014;
   localparam logic [15:0] OFF_CSTS   = 16'h001C;
   localparam logic [15:0] OFF_NSSR   = 16'h0020;
   localparam logic [15:0] OFF_CMBLOC = 16'h0038;
   localparam logic [15:0] OFF_CMBSZ  = 16'h003C;

   // word indexes of the words the back end touches by itself
   localparam logic [IDX_W-1:0] IDX_CAP_LO = IDX_W'(OFF_CAP_LO >> 2);
   localparam logic [IDX_W-1:0] IDX_CAP_HI = IDX_W'(OFF_CAP_HI >> 2);
   localparam logic [IDX_W-1:0] IDX_VS     = IDX_W'(OFF_VS >> 2);
   localparam logic [IDX_W-1:0] IDX_INTMS  = IDX_W'(OFF_INTMS >> 2);
   localparam logic [IDX_W-1:0] IDX_CC     = IDX_W'(OFF_CC >> 2);
   localparam logic [IDX_W-1:0] IDX_CSTS   = IDX_W'(OFF_CSTS >> 2);

   // access modes
   localparam logic [1:0] MODE_RD32 = 2'd0;
   localparam logic [1:0] MODE_WR32 = 2'd1;
   localparam logic [1:0] MODE_RD64 = 2'd2;
   localparam logic [1:0] MODE_WR64 = 2'd3;

   // two-entry queues
   localparam logic [1:0] QUEUE_FULL = 2'd2;

   typedef enum logic [3:0] {
      KIND_RD32,
      KIND_RD64,
      KIND_WR32,
      KIND_WR64,
      KIND_IGNORE,
      KIND_MASK_SET,
      KIND_MASK_CLR,
      KIND_SUBSYS_RESET,
      KIND_OOR_RD32,
      KIND_OOR_RD64,
      KIND_OOR_WR
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_LO,
      ST_RD_HI,
      ST_RMW,
      ST_WR_HI
   } back_state_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] idx;
      logic [63:0]      data;
   } cmd_type;

   typedef struct packed {
      logic [63:0] read_data;
      logic        out_of_range;
   } rsp_type;

   typedef struct packed {
      logic clearing;
   } back_status_type;

   function automatic logic [31:0] reset_word(input logic [IDX_W-1:0] idx);
      logic [31:0] value;
      case (idx)
         IDX_CAP_LO: value = CAP_VALUE[31:0];
         IDX_CAP_HI: value = CAP_VALUE[63:32];
         IDX_VS:     value = VS_VALUE;
         default:    value = 32'h0;
      endcase
      return value;
   endfunction

endpackage

/* sv/nvme_controller_register_file.sv */
// ----------------------------------------------------------------------------
// nvme_controller_register_file: bar0 register space of an nvme controller
// results: out-of-range, ignored and plain 32-bit writes answer in ST_IDLE on accept;
// 32-bit reads via ST_RD_LO, mask writes via ST_RMW, subsystem reset and 64-bit writes
// via ST_WR_HI, 64-bit reads via ST_RD_LO then ST_RD_HI; one transaction at a time
// reset: synchronous; a clearing pass over all STORE_WORDS (2048) words reloads the store
// ----------------------------------------------------------------------------
module nvme_controller_register_file (
   input  logic        clock,
   input  logic        reset,
   // request queue side
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_offset,
   input  logic [63:0] req_write_data,
   // result queue side
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_read_data,
   output logic        rsp_out_of_range
);

   // front to back: classified transaction at the head of the command queue
   logic                       cmd_valid;
   nvmrf_pkg::cmd_type         cmd_head;
   logic                       cmd_ready;
   // back status: clearing pass in progress holds off new transactions
   nvmrf_pkg::back_status_type status;
   // back to result queue
   logic                       rsp_push;
   nvmrf_pkg::rsp_type         rsp_data;
   logic                       rsp_space;

   // front: range check, special-word decode, subsystem-reset magic compare
   nvmrf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_offset     (req_offset),
      .req_write_data (req_write_data),
      .status         (status),
      .cmd_valid      (cmd_valid),
      .cmd_head       (cmd_head),
      .cmd_ready      (cmd_ready)
   );

   // back: word store plus sequencer; a transaction starts only when the
   // result queue has room, so its single result always fits
   nvmrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_ready (cmd_ready),
      .rsp_space (rsp_space),
      .rsp_push  (rsp_push),
      .rsp_data  (rsp_data),
      .status    (status)
   );

   // result queue: results wait here while the back goes on
   nvmrf_rsp_queue u_rsp_queue (
      .clock            (clock),
      .reset            (reset),
      .rsp_push         (rsp_push),
      .rsp_data         (rsp_data),
      .rsp_space        (rsp_space),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_read_data    (rsp_read_data),
      .rsp_out_of_range (rsp_out_of_range)
   );

endmodule

/* sv/nvmrf_front.sv */
// ----------------------------------------------------------------------------
// nvmrf_front
// accepts bus transactions, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module nvmrf_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [1:0]                 req_mode,
   input  logic [15:0]                req_offset,
   input  logic [63:0]                req_write_data,
   input  nvmrf_pkg::back_status_type status,
   output logic                       cmd_valid,
   output nvmrf_pkg::cmd_type         cmd_head,
   input  logic                       cmd_ready
);

   logic [15:0]            off_al;
   logic [16:0]            off_ext;
   logic                   in_space;
   nvmrf_pkg::cmd_type     cmd_new;
   nvmrf_pkg::cmd_type     queue_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;
   logic                   push_ok;
   logic                   pop_ok;

   // classification
   always_comb begin
      off_al  = {req_offset[15:2], 2'b00};
      off_ext = {1'b0, off_al};
      if (req_mode[1]) begin
         in_space = (off_ext + 17'd8) <= nvmrf_pkg::SPACE_LIMIT;
      end else begin
         in_space = off_ext < nvmrf_pkg::SPACE_LIMIT;
      end
      cmd_new.idx  = off_al[nvmrf_pkg::IDX_W+1:2];
      cmd_new.data = req_write_data;
      case (req_mode)
         nvmrf_pkg::MODE_RD32: begin
            cmd_new.kind = in_space ? nvmrf_pkg::KIND_RD32 : nvmrf_pkg::KIND_OOR_RD32;
         end
         nvmrf_pkg::MODE_RD64: begin
            cmd_new.kind = in_space ? nvmrf_pkg::KIND_RD64 : nvmrf_pkg::KIND_OOR_RD64;
         end
         nvmrf_pkg::MODE_WR64: begin
            cmd_new.kind = in_space ? nvmrf_pkg::KIND_WR64 : nvmrf_pkg::KIND_OOR_WR;
         end
         default: begin
            if (!in_space) begin
               cmd_new.kind = nvmrf_pkg::KIND_OOR_WR;
            end else begin
               case (off_al)
                  nvmrf_pkg::OFF_CAP_LO, nvmrf_pkg::OFF_CAP_HI, nvmrf_pkg::OFF_VS,
                  nvmrf_pkg::OFF_CSTS, nvmrf_pkg::OFF_CMBLOC, nvmrf_pkg::OFF_CMBSZ: begin
                     cmd_new.kind = nvmrf_pkg::KIND_IGNORE;
                  end
                  nvmrf_pkg::OFF_INTMS: cmd_new.kind = nvmrf_pkg::KIND_MASK_SET;
                  nvmrf_pkg::OFF_INTMC: cmd_new.kind = nvmrf_pkg::KIND_MASK_CLR;
                  nvmrf_pkg::OFF_NSSR: begin
                     cmd_new.kind = (req_write_data[31:0] == nvmrf_pkg::NSSR_MAGIC) ?
                                    nvmrf_pkg::KIND_SUBSYS_RESET : nvmrf_pkg::KIND_IGNORE;
                  end
                  default: cmd_new.kind = nvmrf_pkg::KIND_WR32;
               endcase
            end
         end
      endcase
   end

   // queue control
   always_comb begin
      req_full  = (count_ff == nvmrf_pkg::QUEUE_FULL) || status.clearing;
      push_ok   = req_push && !req_full;
      cmd_valid = count_ff != 2'd0;
      pop_ok    = cmd_valid && cmd_ready;
      cmd_head  = queue_ff[rd_ptr_ff];
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

/* sv/nvmrf_back.sv */
// ----------------------------------------------------------------------------
// nvmrf_back
// word store and the sequencer that carries out queued transactions
// ----------------------------------------------------------------------------
module nvmrf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   input  nvmrf_pkg::cmd_type         cmd_head,
   output logic                       cmd_ready,
   input  logic                       rsp_space,
   output logic                       rsp_push,
   output nvmrf_pkg::rsp_type         rsp_data,
   output nvmrf_pkg::back_status_type status
);

   localparam int unsigned IW = nvmrf_pkg::IDX_W;

   logic [31:0]               store_mem [nvmrf_pkg::STORE_WORDS];
   logic [31:0]               rdata_ff;
   nvmrf_pkg::back_state_type state_ff, state_in;
   nvmrf_pkg::cmd_type        cmd_ff, cmd_in;
   logic [31:0]               lo_ff, lo_in;
   logic [IW-1:0]             clr_ff, clr_in;
   logic                      mem_we;
   logic [IW-1:0]             mem_waddr;
   logic [31:0]               mem_wdata;
   logic [IW-1:0]             mem_raddr;
   logic                      take;

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      lo_in           = lo_ff;
      clr_in          = clr_ff;
      mem_we          = 1'b0;
      mem_waddr       = cmd_head.idx;
      mem_wdata       = cmd_head.data[31:0];
      mem_raddr       = cmd_head.idx;
      cmd_ready       = 1'b0;
      rsp_push        = 1'b0;
      rsp_data        = '0;
      take            = 1'b0;
      status.clearing = state_ff == nvmrf_pkg::ST_CLEAR;
      case (state_ff)
         nvmrf_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = nvmrf_pkg::reset_word(clr_ff);
            clr_in    = clr_ff + IW'(1);
            if (clr_ff == nvmrf_pkg::LAST_IDX) begin
               state_in = nvmrf_pkg::ST_IDLE;
            end
         end
         nvmrf_pkg::ST_IDLE: begin
            cmd_ready = rsp_space;
            take      = cmd_valid && rsp_space;
            if (take) begin
               cmd_in = cmd_head;
               case (cmd_head.kind)
                  nvmrf_pkg::KIND_RD32, nvmrf_pkg::KIND_RD64: begin
                     state_in = nvmrf_pkg::ST_RD_LO;
                  end
                  nvmrf_pkg::KIND_WR32: begin
                     mem_we   = 1'b1;
                     rsp_push = 1'b1;
                  end
                  nvmrf_pkg::KIND_WR64: begin
                     mem_we   = 1'b1;
                     state_in = nvmrf_pkg::ST_WR_HI;
                  end
                  nvmrf_pkg::KIND_MASK_SET, nvmrf_pkg::KIND_MASK_CLR: begin
                     mem_raddr = nvmrf_pkg::IDX_INTMS;
                     state_in  = nvmrf_pkg::ST_RMW;
                  end
                  nvmrf_pkg::KIND_SUBSYS_RESET: begin
                     mem_we    = 1'b1;
                     mem_waddr = nvmrf_pkg::IDX_CSTS;
                     mem_wdata = 32'h0;
                     state_in  = nvmrf_pkg::ST_WR_HI;
                  end
                  nvmrf_pkg::KIND_OOR_RD32: begin
                     rsp_push              = 1'b1;
                     rsp_data.read_data    = {32'h0, nvmrf_pkg::ONES_32};
                     rsp_data.out_of_range = 1'b1;
                  end
                  nvmrf_pkg::KIND_OOR_RD64: begin
                     rsp_push              = 1'b1;
                     rsp_data.read_data    = nvmrf_pkg::ONES_64;
                     rsp_data.out_of_range = 1'b1;
                  end
                  nvmrf_pkg::KIND_OOR_WR: begin
                     rsp_push              = 1'b1;
                     rsp_data.out_of_range = 1'b1;
                  end
                  default: begin
                     rsp_push = 1'b1;
                  end
               endcase
            end
         end
         nvmrf_pkg::ST_RD_LO: begin
            if (cmd_ff.kind == nvmrf_pkg::KIND_RD64) begin
               lo_in     = rdata_ff;
               mem_raddr = cmd_ff.idx + IW'(1);
               state_in  = nvmrf_pkg::ST_RD_HI;
            end else begin
               rsp_push           = 1'b1;
               rsp_data.read_data = {32'h0, rdata_ff};
               state_in           = nvmrf_pkg::ST_IDLE;
            end
         end
         nvmrf_pkg::ST_RD_HI: begin
            rsp_push           = 1'b1;
            rsp_data.read_data = {rdata_ff, lo_ff};
            state_in           = nvmrf_pkg::ST_IDLE;
         end
         nvmrf_pkg::ST_RMW: begin
            mem_we    = 1'b1;
            mem_waddr = nvmrf_pkg::IDX_INTMS;
            mem_wdata = (cmd_ff.kind == nvmrf_pkg::KIND_MASK_SET) ?
                        (rdata_ff | cmd_ff.data[31:0]) : (rdata_ff & ~cmd_ff.data[31:0]);
            rsp_push  = 1'b1;
            state_in  = nvmrf_pkg::ST_IDLE;
         end
         nvmrf_pkg::ST_WR_HI: begin
            mem_we = 1'b1;
            if (cmd_ff.kind == nvmrf_pkg::KIND_SUBSYS_RESET) begin
               mem_waddr = nvmrf_pkg::IDX_CC;
               mem_wdata = 32'h0;
            end else begin
               mem_waddr = cmd_ff.idx + IW'(1);
               mem_wdata = cmd_ff.data[63:32];
            end
            rsp_push = 1'b1;
            state_in = nvmrf_pkg::ST_IDLE;
         end
         default: begin
            state_in = nvmrf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nvmrf_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      lo_ff  <= lo_in;
   end

   // word store: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_mem[mem_raddr];
   end

endmodule

/* sv/nvmrf_rsp_queue.sv */
// ----------------------------------------------------------------------------
// nvmrf_rsp_queue
// two-entry result queue toward the bus side
// ----------------------------------------------------------------------------
module nvmrf_rsp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               rsp_push,
   input  nvmrf_pkg::rsp_type rsp_data,
   output logic               rsp_space,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [63:0]        rsp_read_data,
   output logic               rsp_out_of_range
);

   nvmrf_pkg::rsp_type queue_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;
   logic               pop_ok;

   always_comb begin
      rsp_space        = count_ff != nvmrf_pkg::QUEUE_FULL;
      rsp_empty        = count_ff == 2'd0;
      pop_ok           = rsp_pop && !rsp_empty;
      rsp_read_data    = queue_ff[rd_ptr_ff].read_data;
      rsp_out_of_range = queue_ff[rd_ptr_ff].out_of_range;
      wr_ptr_in        = rsp_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in        = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      case ({rsp_push, pop_ok})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         queue_ff[wr_ptr_ff] <= rsp_data;
      end
   end

endmodule

/* sv/nvmrf_checker.sv */
// ----------------------------------------------------------------------------
// nvmrf_checker
// port-level checks of the nvme controller register file, bound to the top
// ----------------------------------------------------------------------------
`include "nvme_controller_register_file_defines.svh"

module nvmrf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [1:0]  req_mode,
   input logic [15:0] req_offset,
   input logic [63:0] req_write_data,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [63:0] rsp_read_data,
   input logic        rsp_out_of_range
);

   logic        oor_data_ok;
   logic        rsp_waiting;
   logic [64:0] rsp_view;

   assign oor_data_ok = rsp_read_data == 64'hFFFF_FFFF_FFFF_FFFF ||
                        rsp_read_data == 64'h0000_0000_FFFF_FFFF ||
                        rsp_read_data == 64'h0;
   assign rsp_waiting = !rsp_empty && !rsp_pop;
   assign rsp_view    = {rsp_read_data, rsp_out_of_range};

   // out-of-range result carries ones of the access width or zero
   `NVMRF_ASSERT_SAME(a_oor_data, clock, reset, !rsp_empty && rsp_out_of_range, oor_data_ok)

   // clearing pass keeps the request side closed right after reset
   `NVMRF_ASSERT_SAME(a_clear_full, clock, 1'b0, $fell(reset), req_full)

   // reset empties the result queue
   `NVMRF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty)

   // a waiting result holds until taken
   `NVMRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_waiting, !rsp_empty && $stable(rsp_view))

endmodule

bind nvme_controller_register_file nvmrf_checker u_checker (.*);
